FILE: rtl/core/mstk_pkg.sv
package mstk_pkg;

  // Grid limit used for the dimension check.
  localparam int MAX_DIM = 1024;

  localparam int DimW   = 11;
  localparam int IdxW   = 22;
  localparam int RegW   = 47;
  localparam int CoefW  = 48;
  localparam int DiagW  = 50;
  localparam int CfgIdxW = 3;
  localparam int NumSlots = 7;

  localparam logic [DimW-1:0] CellsReset = 11'd16;
  localparam logic [RegW-1:0] ViscReset  = 47'd16777216;
  localparam logic [RegW-1:0] InvHReset  = 47'd1048576;

  localparam logic signed [CoefW-1:0] OneQ16  = 48'sd65536;
  localparam logic signed [CoefW-1:0] CoefMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [CoefW-1:0] CoefMin = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    KIND_U   = 2'd0,
    KIND_V   = 2'd1,
    KIND_P   = 2'd2,
    KIND_BAD = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CELLS_X = 3'd0,
    CFG_CELLS_Y = 3'd1,
    CFG_VISC_HX = 3'd2,
    CFG_VISC_HY = 3'd3,
    CFG_INV_HX  = 3'd4,
    CFG_INV_HY  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    kind_e           kind;
    logic [DimW-1:0] coord_i;
    logic [DimW-1:0] coord_j;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0]         row_index;
    logic [IdxW-1:0]         col_index;
    logic signed [CoefW-1:0] coeff;
    logic                    rhs_one;
    logic                    last;
    logic                    error;
  } out_word_t;

endpackage

FILE: rtl/core/mac_stokes_matrix_row_generator_top.sv
// MAC staggered-grid Stokes matrix row generator.
// Input channel (in_valid_i / in_ready_o / in_word_i): one word names an
// unknown by kind (u face, v face, pressure cell) and its coordinates.
// Output channel (out_valid_o / out_ready_i / out_word_o): one word per
// entry of that unknown's sparse matrix row, diagonal first, last set on the
// final word. A bad kind or coordinate, or a bad grid size, gives a single
// word with error and last set and everything else zero.
// Configuration channel (cfg_valid_i / cfg_ready_o): writes the grid size
// and the four Q31.16 scale registers; it is always ready and must only be
// used while the block is idle.
//
// Pipeline: an accepted input word passes through three pipeline stages
// and a row buffer before the first word of its row leaves. A row has
// between one and seven words; the single output port emitting one word
// per cycle while the receiver is ready sets the rate.
// While a row drains, later inputs keep entering the pipeline behind it.
//
// Reset clears all valid bits and loads the default configuration. When the
// receiver stalls, the current word holds and the pipeline fills up and
// then backs up to the input without losing or repeating anything.
module mac_stokes_matrix_row_generator_top
  import mstk_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [RegW-1:0]     cfg_data_i
);

  // Boundary and position flags, worked out once at the first stage.
  typedef struct packed {
    logic i_zero;
    logic j_zero;
    logic j_top;
    logic j_eq_m;
    logic i_lt_n;
    logic i1_lt_n;
  } flags_t;

  typedef struct packed {
    kind_e           kind;
    logic            err;
    flags_t          flg;
    logic [DimW-1:0] ci;
    logic [DimW-1:0] cj;
    logic [IdxW-1:0] i_m;
    logic [IdxW-1:0] n_m;
  } s1_t;

  typedef struct packed {
    kind_e            kind;
    logic             err;
    flags_t           flg;
    logic [IdxW-1:0]  row_u;
    logic [IdxW-1:0]  imi_j;
    logic [IdxW-1:0]  sv;
    logic [IdxW-1:0]  nmn;
    logic [DiagW-1:0] du_a;
    logic [DiagW-1:0] du_b;
    logic [DiagW-1:0] dv_a;
    logic [DiagW-1:0] dv_b;
  } s2_t;

  typedef struct packed {
    kind_e            kind;
    logic             err;
    flags_t           flg;
    logic [IdxW-1:0]  row_u;
    logic [IdxW-1:0]  row_v;
    logic [IdxW-1:0]  sp_u;
    logic [DiagW-1:0] diag;
  } s3_t;

  function automatic logic signed [CoefW-1:0] sat_pos(input logic [DiagW-1:0] v);
    if (v > DiagW'(CoefMax)) begin
      return CoefMax;
    end
    return $signed(v[CoefW-1:0]);
  endfunction

  // Negates a nonnegative magnitude and clamps at the most negative value.
  function automatic logic signed [CoefW-1:0] sat_neg(input logic [CoefW-1:0] mag);
    if (mag > CoefW'(CoefMax)) begin
      return CoefMin;
    end
    return -$signed(mag);
  endfunction

  // Configuration registers.
  logic [DimW-1:0] cells_x_q, cells_y_q;
  logic [RegW-1:0] visc_hx_q, visc_hy_q, inv_hx_q, inv_hy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= CellsReset;
      cells_y_q <= CellsReset;
      visc_hx_q <= ViscReset;
      visc_hy_q <= ViscReset;
      inv_hx_q  <= InvHReset;
      inv_hy_q  <= InvHReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CELLS_X: cells_x_q <= cfg_data_i[DimW-1:0];
        CFG_CELLS_Y: cells_y_q <= cfg_data_i[DimW-1:0];
        CFG_VISC_HX: visc_hx_q <= cfg_data_i;
        CFG_VISC_HY: visc_hy_q <= cfg_data_i;
        CFG_INV_HX:  inv_hx_q  <= cfg_data_i;
        CFG_INV_HY:  inv_hy_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and the ready chain running back from the buffer.
  logic s1_v_q, s2_v_q, s3_v_q, buf_valid_q;
  logic s1_ready, s2_ready, s3_ready, buf_ready;
  logic out_last;

  assign buf_ready  = !buf_valid_q || (out_ready_i && out_last);
  assign s3_ready   = !s3_v_q || buf_ready;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Stage 1: range checks, flags and the two index products.
  s1_t s1_d, s1_q;
  logic dims_ok, crd_ok;

  always_comb begin
    logic [DimW-1:0] ci, cj;
    ci = in_word_i.coord_i;
    cj = in_word_i.coord_j;
    dims_ok = (cells_x_q != '0) && (int'(cells_x_q) <= MAX_DIM) &&
              (cells_y_q != '0) && (int'(cells_y_q) <= MAX_DIM);
    case (in_word_i.kind)
      KIND_U:  crd_ok = (ci <= cells_x_q) && (cj < cells_y_q);
      KIND_V:  crd_ok = (ci < cells_x_q) && (cj <= cells_y_q);
      KIND_P:  crd_ok = (ci < cells_x_q) && (cj < cells_y_q);
      default: crd_ok = 1'b0;
    endcase
    s1_d.kind        = in_word_i.kind;
    s1_d.err         = !(dims_ok && crd_ok);
    s1_d.ci          = ci;
    s1_d.cj          = cj;
    s1_d.i_m         = IdxW'(ci) * IdxW'(cells_y_q);
    s1_d.n_m         = IdxW'(cells_x_q) * IdxW'(cells_y_q);
    s1_d.flg.i_zero  = (ci == '0);
    s1_d.flg.j_zero  = (cj == '0);
    s1_d.flg.j_top   = (({1'b0, cj} + (DimW+1)'(1)) == {1'b0, cells_y_q});
    s1_d.flg.j_eq_m  = (cj == cells_y_q);
    s1_d.flg.i_lt_n  = (ci < cells_x_q);
    s1_d.flg.i1_lt_n = (({1'b0, ci} + (DimW+1)'(1)) < {1'b0, cells_x_q});
  end

  // Stage 2: base indices and partial diagonal sums.
  s2_t s2_d, s2_q;

  always_comb begin
    logic [DiagW-1:0] ax, ay;
    ax = DiagW'(visc_hx_q);
    ay = DiagW'(visc_hy_q);
    s2_d.kind  = s1_q.kind;
    s2_d.err   = s1_q.err;
    s2_d.flg   = s1_q.flg;
    s2_d.row_u = s1_q.i_m + IdxW'(s1_q.cj);
    s2_d.imi_j = s1_q.i_m + IdxW'(s1_q.ci) + IdxW'(s1_q.cj);
    s2_d.sv    = s1_q.n_m + IdxW'(cells_y_q);
    s2_d.nmn   = s1_q.n_m + IdxW'(cells_x_q);
    // Terms at a wall are doubled since the wall sits half a cell away.
    s2_d.du_a  = ax + (s1_q.flg.j_zero ? (ay << 1) : ay);
    s2_d.du_b  = (s1_q.flg.j_top ? (ay << 1) : ay) + (s1_q.flg.i_lt_n ? ax : '0);
    s2_d.dv_a  = (s1_q.flg.i_zero ? (ax << 1) : ax) + (s1_q.flg.i1_lt_n ? ax : '0);
    s2_d.dv_b  = ay << 1;
  end

  // Stage 3: v and pressure row numbers, full diagonal.
  s3_t s3_d, s3_q;

  always_comb begin
    s3_d.kind  = s2_q.kind;
    s3_d.err   = s2_q.err;
    s3_d.flg   = s2_q.flg;
    s3_d.row_u = s2_q.row_u;
    s3_d.row_v = s2_q.sv + s2_q.imi_j;
    s3_d.sp_u  = s2_q.sv + s2_q.nmn + s2_q.row_u;
    s3_d.diag  = (s2_q.kind == KIND_U) ? (s2_q.du_a + s2_q.du_b)
                                       : (s2_q.dv_a + s2_q.dv_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_q <= s1_d;
    end
    if (s2_ready) begin
      s2_q <= s2_d;
    end
    if (s3_ready) begin
      s3_q <= s3_d;
    end
  end

  // Row assembly: each entry has a fixed slot, and a mask marks the slots
  // present. Slot 0 is always the diagonal.
  logic [IdxW-1:0]         slot_col   [NumSlots];
  logic signed [CoefW-1:0] slot_coeff [NumSlots];
  logic [NumSlots-1:0]     slot_mask;
  logic [IdxW-1:0]         slot_row;
  logic                    slot_rhs, slot_err;

  always_comb begin
    logic signed [CoefW-1:0] neg_ax, neg_ay, neg_gx, neg_gy, pos_gx, pos_gy;
    logic signed [CoefW-1:0] neg_2gx, diag_c;
    logic [IdxW-1:0] m_x, m_p1;
    neg_ax  = -$signed(CoefW'(visc_hx_q));
    neg_ay  = -$signed(CoefW'(visc_hy_q));
    pos_gx  = $signed(CoefW'(inv_hx_q));
    pos_gy  = $signed(CoefW'(inv_hy_q));
    neg_gx  = -pos_gx;
    neg_gy  = -pos_gy;
    neg_2gx = sat_neg({inv_hx_q, 1'b0});
    diag_c  = sat_pos(s3_q.diag);
    m_x     = IdxW'(cells_y_q);
    m_p1    = m_x + IdxW'(1);

    for (int k = 0; k < NumSlots; k++) begin
      slot_col[k]   = '0;
      slot_coeff[k] = '0;
    end
    slot_mask = '0;
    slot_row  = '0;
    slot_rhs  = 1'b0;
    slot_err  = s3_q.err;

    if (!s3_q.err) begin
      case (s3_q.kind)
        KIND_U: begin
          slot_row    = s3_q.row_u;
          slot_col[0] = s3_q.row_u;
          if (s3_q.flg.i_zero) begin
            // Inflow boundary: identity row with a unit right-hand side.
            slot_coeff[0] = OneQ16;
            slot_mask     = NumSlots'(1);
            slot_rhs      = 1'b1;
          end else begin
            slot_coeff[0] = diag_c;
            slot_col[1]   = s3_q.row_u - m_x;
            slot_coeff[1] = neg_ax;
            slot_col[2]   = s3_q.row_u - IdxW'(1);
            slot_coeff[2] = neg_ay;
            slot_col[3]   = s3_q.row_u + IdxW'(1);
            slot_coeff[3] = neg_ay;
            slot_col[4]   = s3_q.row_u + m_x;
            slot_coeff[4] = neg_ax;
            // At the outflow face only the inner pressure remains, doubled.
            slot_col[5]   = s3_q.sp_u - m_x;
            slot_coeff[5] = s3_q.flg.i_lt_n ? neg_gx : neg_2gx;
            slot_col[6]   = s3_q.sp_u;
            slot_coeff[6] = pos_gx;
            slot_mask = {s3_q.flg.i_lt_n, 1'b1, s3_q.flg.i_lt_n, !s3_q.flg.j_top,
                         !s3_q.flg.j_zero, 1'b1, 1'b1};
          end
        end
        KIND_V: begin
          slot_row    = s3_q.row_v;
          slot_col[0] = s3_q.row_v;
          if (s3_q.flg.j_zero || s3_q.flg.j_eq_m) begin
            slot_coeff[0] = OneQ16;
            slot_mask     = NumSlots'(1);
          end else begin
            slot_coeff[0] = diag_c;
            slot_col[1]   = s3_q.row_v - m_p1;
            slot_coeff[1] = neg_ax;
            slot_col[2]   = s3_q.row_v - IdxW'(1);
            slot_coeff[2] = neg_ay;
            slot_col[3]   = s3_q.row_v + IdxW'(1);
            slot_coeff[3] = neg_ay;
            slot_col[4]   = s3_q.row_v + m_p1;
            slot_coeff[4] = neg_ax;
            slot_col[5]   = s3_q.sp_u;
            slot_coeff[5] = pos_gy;
            slot_col[6]   = s3_q.sp_u - IdxW'(1);
            slot_coeff[6] = neg_gy;
            slot_mask = {1'b1, 1'b1, s3_q.flg.i1_lt_n, 1'b1, 1'b1,
                         !s3_q.flg.i_zero, 1'b1};
          end
        end
        KIND_P: begin
          // Divergence row: the zero diagonal is emitted explicitly.
          slot_row      = s3_q.sp_u;
          slot_col[0]   = s3_q.sp_u;
          slot_col[1]   = s3_q.row_u;
          slot_coeff[1] = neg_gx;
          slot_col[2]   = s3_q.row_u + m_x;
          slot_coeff[2] = pos_gx;
          slot_col[3]   = s3_q.row_v;
          slot_coeff[3] = neg_gy;
          slot_col[4]   = s3_q.row_v + IdxW'(1);
          slot_coeff[4] = pos_gy;
          slot_mask     = NumSlots'(5'b11111);
        end
        default: begin
          slot_err  = 1'b1;
          slot_mask = NumSlots'(1);
        end
      endcase
    end else begin
      slot_mask = NumSlots'(1);
    end
  end

  // Row buffer: drains one word per cycle while the receiver is ready, lowest remaining slot first.
  logic [IdxW-1:0]         buf_row_q;
  logic [IdxW-1:0]         buf_col_q   [NumSlots];
  logic signed [CoefW-1:0] buf_coeff_q [NumSlots];
  logic [NumSlots-1:0]     buf_mask_q, buf_mask_d;
  logic                    buf_rhs_q, buf_err_q;
  logic [NumSlots-1:0]     sel_low, mask_rest;

  assign sel_low   = buf_mask_q & (~buf_mask_q + NumSlots'(1));
  assign mask_rest = buf_mask_q & ~sel_low;
  assign out_last  = (mask_rest == '0);

  always_comb begin
    buf_mask_d = buf_mask_q;
    if (buf_ready) begin
      buf_mask_d = slot_mask;
    end else if (out_ready_i) begin
      buf_mask_d = mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      buf_mask_q  <= '0;
    end else begin
      buf_mask_q <= buf_mask_d;
      if (buf_ready) begin
        buf_valid_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_ready) begin
      buf_row_q   <= slot_row;
      buf_col_q   <= slot_col;
      buf_coeff_q <= slot_coeff;
      buf_rhs_q   <= slot_rhs;
      buf_err_q   <= slot_err;
    end
  end

  always_comb begin
    logic [IdxW-1:0]         col;
    logic signed [CoefW-1:0] cf;
    col = '0;
    cf  = '0;
    for (int k = 0; k < NumSlots; k++) begin
      col = col | (buf_col_q[k] & {IdxW{sel_low[k]}});
      cf  = cf | (buf_coeff_q[k] & {CoefW{sel_low[k]}});
    end
    out_word_o.row_index = buf_row_q;
    out_word_o.col_index = col;
    out_word_o.coeff     = cf;
    out_word_o.rhs_one   = buf_rhs_q;
    out_word_o.last      = out_last;
    out_word_o.error     = buf_err_q;
  end

  assign out_valid_o = buf_valid_q;

endmodule

FILE: rtl/core/mstk_checker.sv
module mstk_checker
  import mstk_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // Set while the next output word opens a new row.
  logic first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      first_q <= out_word_o.last;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.error |->
      out_word_o.last && !out_word_o.rhs_one && out_word_o.coeff == '0 &&
      out_word_o.row_index == '0 && out_word_o.col_index == '0)
    else $error("error word is not a lone zero entry");

  a_rhs_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.rhs_one |->
      out_word_o.last && out_word_o.coeff == OneQ16 &&
      out_word_o.col_index == out_word_o.row_index)
    else $error("unit right-hand side on a row that is not an identity row");

  a_diag_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_q |-> out_word_o.col_index == out_word_o.row_index)
    else $error("row does not open with its diagonal");

endmodule

bind mac_stokes_matrix_row_generator_top mstk_checker u_mstk_checker (.*);

FILE: dv/tb_mac_stokes_matrix_row_generator_top.sv
module tb_mac_stokes_matrix_row_generator_top;
  import mstk_pkg::*;

  // A stalled output never lets the watchdog count this far in a correct run.
  // The longest quiet stretch is the deliberate hold-off below plus a drain.
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 300;
  // Cycles to let pass once the last expected word is in, before a register write.
  localparam int SettleCycles = 8;

  // Register indexes outside the map; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_word_t            in_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [RegW-1:0]     cfg_data_i = '0;

  mac_stokes_matrix_row_generator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Our own copy of the grid size and the four scale registers. It is
  // updated at each accepted register write and starts at the reset values.
  logic [DimW-1:0] grid_n = CellsReset;
  logic [DimW-1:0] grid_m = CellsReset;
  logic [RegW-1:0] visc_x = ViscReset;
  logic [RegW-1:0] visc_y = ViscReset;
  logic [RegW-1:0] grad_x = InvHReset;
  logic [RegW-1:0] grad_y = InvHReset;

  // Requests still to be offered, and the matrix words still to come back.
  in_word_t  requests_q[$];
  out_word_t row_words_due_q[$];
  out_word_t row_buf[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  int fail_count = 0;
  int rows_sent = 0;
  int bad_rows = 0;
  int words_checked = 0;
  int grids_used = 1;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // Saturate an exact 64-bit coefficient to the signed 48-bit output range.
  function automatic logic signed [CoefW-1:0] clamp_coef(input longint v);
    if (v > longint'(CoefMax)) return CoefMax;
    if (v < longint'(CoefMin)) return CoefMin;
    return v[CoefW-1:0];
  endfunction

  function automatic void add_entry(input longint row, input longint col, input longint c);
    out_word_t e;
    e = '0;
    e.row_index = row[IdxW-1:0];
    e.col_index = col[IdxW-1:0];
    e.coeff = clamp_coef(c);
    row_buf = {row_buf, e};
  endfunction

  // Works out the whole sparse row for one accepted request and appends its
  // words, diagonal first, to the queue of words still due.
  task automatic predict_row_words(input in_word_t w);
    longint n, m, ax, ay, gx, gy, i, j, sv, sp, row, d;
    bit ok;
    bit rhs;
    n = grid_n;
    m = grid_m;
    ax = visc_x;
    ay = visc_y;
    gx = grad_x;
    gy = grad_y;
    i = w.coord_i;
    j = w.coord_j;
    rhs = 1'b0;
    ok = (n >= 1 && n <= MAX_DIM && m >= 1 && m <= MAX_DIM);
    if (ok) begin
      case (w.kind)
        KIND_U:  ok = (i <= n && j < m);
        KIND_V:  ok = (i < n && j <= m);
        KIND_P:  ok = (i < n && j < m);
        default: ok = 1'b0;
      endcase
    end
    sv = (n + 1) * m;
    sp = sv + n * (m + 1);
    if (!ok) begin
      // A rejected request is one all-zero word with only error and last set.
      add_entry(0, 0, 0);
      row_buf[0].error = 1'b1;
      bad_rows++;
    end else if (w.kind == KIND_U) begin
      row = i * m + j;
      if (i == 0) begin
        // Inflow face: fixed u = 1.
        add_entry(row, row, longint'(OneQ16));
        rhs = 1'b1;
      end else begin
        d = ax + ((j == 0) ? 2 * ay : ay) + ((j == m - 1) ? 2 * ay : ay) + ((i < n) ? ax : 0);
        add_entry(row, row, d);
        add_entry(row, (i - 1) * m + j, -ax);
        if (j > 0) add_entry(row, i * m + j - 1, -ay);
        if (j < m - 1) add_entry(row, i * m + j + 1, -ay);
        if (i < n) add_entry(row, (i + 1) * m + j, -ax);
        if (i == n) begin
          // Outflow face: the pressure outside is zero, the gap is half a cell.
          add_entry(row, sp + (i - 1) * m + j, -2 * gx);
        end else begin
          add_entry(row, sp + (i - 1) * m + j, -gx);
          add_entry(row, sp + i * m + j, gx);
        end
      end
    end else if (w.kind == KIND_V) begin
      row = sv + i * (m + 1) + j;
      if (j == 0 || j == m) begin
        // Bottom and top walls: fixed v = 0.
        add_entry(row, row, longint'(OneQ16));
      end else begin
        d = ((i == 0) ? 2 * ax : ax) + 2 * ay + ((i + 1 < n) ? ax : 0);
        add_entry(row, row, d);
        if (i > 0) add_entry(row, sv + (i - 1) * (m + 1) + j, -ax);
        add_entry(row, row - 1, -ay);
        add_entry(row, row + 1, -ay);
        if (i + 1 < n) add_entry(row, sv + (i + 1) * (m + 1) + j, -ax);
        add_entry(row, sp + i * m + j, gy);
        add_entry(row, sp + i * m + j - 1, -gy);
      end
    end else begin
      row = sp + i * m + j;
      add_entry(row, row, 0);
      add_entry(row, i * m + j, -gx);
      add_entry(row, (i + 1) * m + j, gx);
      add_entry(row, sv + i * (m + 1) + j, -gy);
      add_entry(row, sv + i * (m + 1) + j + 1, gy);
    end
    foreach (row_buf[k]) row_buf[k].rhs_one = rhs;
    row_buf[row_buf.size() - 1].last = 1'b1;
    row_words_due_q = {row_words_due_q, row_buf};
    row_buf.delete();
  endtask

  // Driver: offers queued requests, idling at random. A word that is not
  // taken stays on the port unchanged until the block accepts it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_row_words(in_word_i);
        rows_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_word_i <= requests_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Hold-off counter: once asked, it keeps the receiver off for a long
  // stretch so the pipeline fills and the input side has to stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HoldCycles;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Monitor: checks every accepted matrix word against the oldest word due
  // and drives ready, kept low while the hold-off counter runs.
  always @(posedge clk_i) begin
    out_word_t want;
    bit holding;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        words_checked++;
        if (row_words_due_q.size() == 0) begin
          report_mismatch($sformatf("word with no row pending: %p", out_word_o));
        end else begin
          want = row_words_due_q.pop_front();
          if (out_word_o.row_index !== want.row_index)
            report_mismatch($sformatf("row_index %0d, want %0d",
                                      out_word_o.row_index, want.row_index));
          if (out_word_o.col_index !== want.col_index)
            report_mismatch($sformatf("col_index %0d, want %0d (row %0d)",
                                      out_word_o.col_index, want.col_index, want.row_index));
          if (out_word_o.coeff !== want.coeff)
            report_mismatch($sformatf("coeff %0d, want %0d (row %0d col %0d)",
                                      out_word_o.coeff, want.coeff,
                                      want.row_index, want.col_index));
          if (out_word_o.rhs_one !== want.rhs_one)
            report_mismatch($sformatf("rhs_one %b, want %b (row %0d)",
                                      out_word_o.rhs_one, want.rhs_one, want.row_index));
          if (out_word_o.last !== want.last)
            report_mismatch($sformatf("last %b, want %b (row %0d col %0d)",
                                      out_word_o.last, want.last,
                                      want.row_index, want.col_index));
          if (out_word_o.error !== want.error)
            report_mismatch($sformatf("error %b, want %b (row %0d)",
                                      out_word_o.error, want.error, want.row_index));
        end
      end
      holding = (hold_go && !hold_taken) || hold_left > 1;
      out_ready_i <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("timeout: nothing moved for %0d cycles, %0d words still due",
                 StallLimit, row_words_due_q.size());
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Writes one register; must be entered at a rising edge. The valid stays
  // high across back-to-back writes and is lowered by the caller.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CELLS_X: grid_n = data[DimW-1:0];
      CFG_CELLS_Y: grid_m = data[DimW-1:0];
      CFG_VISC_HX: visc_x = data;
      CFG_VISC_HY: visc_y = data;
      CFG_INV_HX:  grad_x = data;
      CFG_INV_HY:  grad_y = data;
      default: ;
    endcase
  endtask

  function automatic logic [RegW-1:0] rand_scale(input int bits);
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[RegW-1:0] >> (RegW - bits);
  endfunction

  // The grid size registers only keep their low bits, so junk above them is
  // sometimes sent along to make sure it is dropped.
  function automatic logic [RegW-1:0] size_word(input int cells);
    logic [RegW-1:0] junk;
    junk = $urandom_range(1) ? (rand_scale(RegW) & ~RegW'(11'h7FF)) : '0;
    return junk | RegW'(cells[DimW-1:0]);
  endfunction

  task automatic write_grid(input int n, input int m, input logic [RegW-1:0] ax,
                            input logic [RegW-1:0] ay, input logic [RegW-1:0] gx,
                            input logic [RegW-1:0] gy);
    write_reg(CFG_CELLS_X, size_word(n));
    write_reg(CFG_CELLS_Y, size_word(m));
    write_reg(CFG_VISC_HX, ax);
    write_reg(CFG_VISC_HY, ay);
    write_reg(CFG_INV_HX, gx);
    write_reg(CFG_INV_HY, gy);
    write_reg($urandom_range(1) ? CfgSpareLo : CfgSpareHi, rand_scale(RegW));
    cfg_valid_i <= 1'b0;
    grids_used++;
  endtask

  function automatic void set_idling(input idle_mode_e mode);
    send_idle_pct = (mode == IDLE_SEND) ? 45 : (mode == IDLE_BOTH) ? 31 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 45 : (mode == IDLE_BOTH) ? 31 : 0;
  endfunction

  function automatic void queue_request(input kind_e k, input int i, input int j);
    in_word_t w;
    w.kind = k;
    w.coord_i = i[DimW-1:0];
    w.coord_j = j[DimW-1:0];
    requests_q = {requests_q, w};
  endfunction

  // Favors the edges of the valid range, where the boundary rules live.
  function automatic int pick_coord(input int hi);
    case ($urandom_range(9))
      0: return 0;
      1: return hi;
      2: return (hi > 0) ? hi - 1 : 0;
      3: return (hi > 1) ? 1 : 0;
      default: return $urandom_range(hi);
    endcase
  endfunction

  // Mostly well-formed requests for the current grid; the rest are invalid
  // kinds and coordinates picked anywhere in the field.
  function automatic void queue_random_requests(input int count);
    in_word_t w;
    int r, hi_i, hi_j;
    repeat (count) begin
      r = $urandom_range(99);
      w.kind = kind_e'($urandom_range(2));
      hi_i = (w.kind == KIND_U) ? int'(grid_n) : int'(grid_n) - 1;
      hi_j = (w.kind == KIND_V) ? int'(grid_m) : int'(grid_m) - 1;
      if (r < 6) w.kind = KIND_BAD;
      if (r < 15 || hi_i < 0 || hi_j < 0 || grid_n > MAX_DIM || grid_m > MAX_DIM) begin
        w.coord_i = DimW'($urandom());
        w.coord_j = DimW'($urandom());
      end else begin
        w.coord_i = DimW'(pick_coord(hi_i));
        w.coord_j = DimW'(pick_coord(hi_j));
      end
      requests_q = {requests_q, w};
    end
  endfunction

  // Returns at a rising edge once every request is in and every word is out.
  task automatic wait_rows_done();
    do @(negedge clk_i);
    while (requests_q.size() != 0 || in_valid_i || row_words_due_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n, input int m, input logic [RegW-1:0] ax,
                           input logic [RegW-1:0] ay, input logic [RegW-1:0] gx,
                           input logic [RegW-1:0] gy, input idle_mode_e mode,
                           input int count);
    write_grid(n, m, ax, ay, gx, gy);
    @(negedge clk_i);
    set_idling(mode);
    queue_random_requests(count);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows on the reset grid of 16 x 16: inflow, outflow, walls,
    // corners, interior, pressure cells and requests rejected for each bad kind or coordinate.
    set_idling(IDLE_NONE);
    queue_request(KIND_U, 0, 0);
    queue_request(KIND_U, 0, 15);
    queue_request(KIND_U, 1, 0);
    queue_request(KIND_U, 8, 8);
    queue_request(KIND_U, 16, 0);
    queue_request(KIND_U, 16, 15);
    queue_request(KIND_U, 15, 15);
    queue_request(KIND_V, 0, 0);
    queue_request(KIND_V, 0, 16);
    queue_request(KIND_V, 0, 1);
    queue_request(KIND_V, 15, 8);
    queue_request(KIND_V, 14, 5);
    queue_request(KIND_V, 8, 15);
    queue_request(KIND_P, 0, 0);
    queue_request(KIND_P, 15, 15);
    queue_request(KIND_P, 7, 3);
    queue_request(KIND_BAD, 0, 0);
    queue_request(KIND_BAD, 2047, 2047);
    queue_request(KIND_U, 17, 0);
    queue_request(KIND_U, 0, 16);
    queue_request(KIND_V, 16, 1);
    queue_request(KIND_V, 0, 17);
    queue_request(KIND_P, 16, 0);
    queue_request(KIND_P, 0, 16);
    queue_request(KIND_U, 2047, 2047);
    wait_rows_done();

    // Smallest grid: every face sits on a boundary.
    run_phase(1, 1, 47'd65536, 47'd98304, 47'd65536, 47'd131072, IDLE_SEND, 45);
    wait_rows_done();

    // Largest grid with full-scale coefficients, so diagonals and the
    // doubled outflow gradient saturate. The far corners are hit directly.
    run_phase(MAX_DIM, MAX_DIM, rand_scale(RegW) | 47'h4000_0000_0000,
              {RegW{1'b1}}, {RegW{1'b1}}, {RegW{1'b1}}, IDLE_RECV, 45);
    queue_request(KIND_U, 1024, 1023);
    queue_request(KIND_U, 1024, 0);
    queue_request(KIND_V, 1023, 1024);
    queue_request(KIND_V, 1023, 1);
    queue_request(KIND_P, 1023, 1023);
    wait_rows_done();

    // Small grid under back-pressure: the receiver holds off long enough
    // for the block to fill up and stop taking requests.
    run_phase(3, 2, rand_scale(20), rand_scale(20), rand_scale(20), rand_scale(20),
              IDLE_BOTH, 60);
    hold_go = 1'b1;
    wait_rows_done();

    // Illegal grid sizes: zero cells, and sizes beyond the limit.
    run_phase(0, 2047, rand_scale(30), rand_scale(30), rand_scale(30), rand_scale(30),
              IDLE_NONE, 15);
    wait_rows_done();
    run_phase(1025, 5, rand_scale(30), rand_scale(30), rand_scale(30), rand_scale(30),
              IDLE_BOTH, 15);
    wait_rows_done();

    // All scales zero.
    run_phase(2, 7, '0, '0, '0, '0, IDLE_SEND, 45);
    wait_rows_done();

    // Degenerate strips in each direction.
    run_phase(MAX_DIM, 1, rand_scale(RegW), rand_scale(RegW), rand_scale(RegW),
              rand_scale(RegW), IDLE_RECV, 45);
    wait_rows_done();
    run_phase(1, MAX_DIM, rand_scale(40), rand_scale(40), rand_scale(40), rand_scale(40),
              IDLE_BOTH, 45);
    wait_rows_done();

    // A random small grid with no idling on either side.
    run_phase($urandom_range(12, 1), $urandom_range(12, 1), rand_scale(24), rand_scale(24),
              rand_scale(24), rand_scale(24), IDLE_NONE, 60);
    wait_rows_done();

    repeat (20) @(posedge clk_i);
    if (row_words_due_q.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", row_words_due_q.size()));
    $display("covered %0d rows (%0d rejected) over %0d grid settings", rows_sent, bad_rows,
             grids_used);
    $display("compared %0d matrix words, %0d mismatches", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
